>>> hw/rtl/clipped_color_key_sprite_blit_defines.svh
// Assertion helpers shared by the RTL of the sprite blitter.
`ifndef CLIPPED_COLOR_KEY_SPRITE_BLIT_DEFINES_SVH
`define CLIPPED_COLOR_KEY_SPRITE_BLIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CCKSB_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CCKSB_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/ccksb_pkg.sv
`timescale 1ns / 1ps
package ccksb_pkg;

   localparam int MAX_SPRITE_SIDE = 256;
   localparam int MAX_SCENE_SIDE  = 2048;

   // Sprite counters index up to MAX_SPRITE_SIDE-1; side registers hold up to MAX_SPRITE_SIDE.
   localparam int CountW  = $clog2(MAX_SPRITE_SIDE);
   localparam int SideW   = CountW + 1;
   localparam int SceneW  = $clog2(MAX_SCENE_SIDE) + 1;
   localparam int PosW    = SceneW;
   localparam int RowW    = SceneW + 1;
   localparam int OffsetW = 22;
   localparam int PixelW  = 8;
   localparam int CsrIdxW = 3;
   localparam int CsrDataW = SceneW;

   localparam logic [SideW-1:0] SideMax = SideW'(MAX_SPRITE_SIDE);

   typedef enum logic [CsrIdxW-1:0] {
      CSR_SPRITE_X      = 3'd0,
      CSR_SPRITE_Y      = 3'd1,
      CSR_SPRITE_WIDTH  = 3'd2,
      CSR_SPRITE_HEIGHT = 3'd3,
      CSR_SCENE_WIDTH   = 3'd4,
      CSR_SCENE_HEIGHT  = 3'd5,
      CSR_KEY_COLOR     = 3'd6,
      CSR_KEY_ENABLE    = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [PosW-1:0]    sprite_x;      // two's complement
      logic [PosW-1:0]    sprite_y;      // two's complement
      logic [SideW-1:0]   sprite_width;
      logic [SideW-1:0]   sprite_height;
      logic [SceneW-1:0]  scene_width;
      logic [SceneW-1:0]  scene_height;
      logic [PixelW-1:0]  key_color;
      logic               key_enable;
      logic [OffsetW-1:0] start_base;    // sprite_y * scene_width, mod 2^OffsetW
   } cfg_type;

   // Zero acts as one, anything above the maximum acts as the maximum.
   function automatic logic [SideW-1:0] clamp_side(input logic [SideW-1:0] v);
      logic [SideW-1:0] r;
      begin
         if (v == '0) begin
            r = SideW'(1);
         end else if (v > SideMax) begin
            r = SideMax;
         end else begin
            r = v;
         end
         return r;
      end
   endfunction

endpackage

>>> hw/rtl/ccksb_cfg.sv
`timescale 1ns / 1ps
module ccksb_cfg (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ccksb_pkg::CsrIdxW-1:0]      csr_index,
   input  logic [ccksb_pkg::CsrDataW-1:0]     csr_data,
   output ccksb_pkg::cfg_type                 cfg
);

   ccksb_pkg::cfg_type cfg_ff;
   ccksb_pkg::cfg_type cfg_in;
   logic signed [ccksb_pkg::PosW+ccksb_pkg::SceneW:0] product;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (ccksb_pkg::csr_index_type'(csr_index))
            ccksb_pkg::CSR_SPRITE_X:      cfg_in.sprite_x = csr_data[ccksb_pkg::PosW-1:0];
            ccksb_pkg::CSR_SPRITE_Y:      cfg_in.sprite_y = csr_data[ccksb_pkg::PosW-1:0];
            ccksb_pkg::CSR_SPRITE_WIDTH:
               cfg_in.sprite_width = csr_data[ccksb_pkg::SideW-1:0];
            ccksb_pkg::CSR_SPRITE_HEIGHT:
               cfg_in.sprite_height = csr_data[ccksb_pkg::SideW-1:0];
            ccksb_pkg::CSR_SCENE_WIDTH:
               cfg_in.scene_width = csr_data[ccksb_pkg::SceneW-1:0];
            ccksb_pkg::CSR_SCENE_HEIGHT:
               cfg_in.scene_height = csr_data[ccksb_pkg::SceneW-1:0];
            ccksb_pkg::CSR_KEY_COLOR:     cfg_in.key_color = csr_data[ccksb_pkg::PixelW-1:0];
            ccksb_pkg::CSR_KEY_ENABLE:    cfg_in.key_enable = csr_data[0];
            default: ;
         endcase
      end
      // Track the start base from the new values so it is ready on the next cycle.
      product = $signed(cfg_in.sprite_y) * $signed({1'b0, cfg_in.scene_width});
      cfg_in.start_base = product[ccksb_pkg::OffsetW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sprite_x      <= '0;
         cfg_ff.sprite_y      <= '0;
         cfg_ff.sprite_width  <= ccksb_pkg::SideW'(1);
         cfg_ff.sprite_height <= ccksb_pkg::SideW'(1);
         cfg_ff.scene_width   <= ccksb_pkg::SceneW'(640);
         cfg_ff.scene_height  <= ccksb_pkg::SceneW'(480);
         cfg_ff.key_color     <= '0;
         cfg_ff.key_enable    <= 1'b1;
         cfg_ff.start_base    <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> hw/rtl/clipped_color_key_sprite_blit.sv
`timescale 1ns / 1ps
// Colour-key sprite blitter with scene clipping. Sprite pixels arrive on the
// req_ stream in raster order, one request per pixel, and each yields one
// rsp_ item in the cycle after it is taken: the scene byte offset (row times pitch plus
// column, modulo 2^22), the pixel itself, a write enable in rsp_tuser and
// rsp_tlast on the final pixel of the sprite; the next pixel after that
// starts a new sprite. The enable is set only when the target row and column
// lie inside the scene and, with key_enable set, the pixel differs from
// key_color; when it is clear the offset reads as zero. The block sustains
// one pixel per clock: the row/column counters, the running row base adder
// and the clip compares all settle combinationally between the request and the
// output register, and a new request is taken whenever the output register is
// empty or being drained. Registers are written through the csr_ port, which
// is always ready; the start base (sprite_y times scene_width) is formed by a
// single multiplier at write time, so a sprite may start on the cycle after a
// write. sprite_y and the start base are sampled at each sprite's first pixel;
// the other registers act immediately.
module clipped_color_key_sprite_blit (
   input  logic                             clock,
   input  logic                             reset,
   // configuration writes
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ccksb_pkg::CsrIdxW-1:0]    csr_index,
   input  logic [ccksb_pkg::CsrDataW-1:0]   csr_data,
   // sprite pixels
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [7:0]                       req_tdata,   // [7:0] pixel
   // scene writes
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [31:0]                      rsp_tdata,   // [21:0] scene_offset, [29:22] pixel_out
   output logic                             rsp_tuser,   // [0] write_enable
   output logic                             rsp_tlast    // last_pixel
);

`include "clipped_color_key_sprite_blit_defines.svh"

   ccksb_pkg::cfg_type cfg;

   ccksb_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // Sprite walk state
   logic [ccksb_pkg::CountW-1:0]  col_cnt_ff, col_cnt_in;
   logic [ccksb_pkg::CountW-1:0]  row_cnt_ff, row_cnt_in;
   logic [ccksb_pkg::RowW-1:0]    scene_row_ff, scene_row_in;
   logic [ccksb_pkg::OffsetW-1:0] row_base_ff, row_base_in;

   // Output register
   logic                          rsp_valid_ff;
   logic                          rsp_we_ff;
   logic [ccksb_pkg::OffsetW-1:0] rsp_offset_ff;
   logic [ccksb_pkg::PixelW-1:0]  rsp_pixel_ff;
   logic                          rsp_last_ff;

   logic                          req_accept;
   logic                          first_pixel;
   logic [ccksb_pkg::SideW-1:0]   width_eff;
   logic [ccksb_pkg::SideW-1:0]   height_eff;
   logic                          row_end;
   logic                          last_in;
   logic [ccksb_pkg::RowW-1:0]    scene_row_cur;
   logic [ccksb_pkg::OffsetW-1:0] row_base_cur;
   logic [ccksb_pkg::RowW-1:0]    col_pos;
   logic                          in_scene;
   logic                          we_in;
   logic [ccksb_pkg::OffsetW-1:0] offset_in;
   logic [ccksb_pkg::PixelW-1:0]  pixel;

   // Take a request whenever the output slot is free or being emptied.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign pixel      = req_tdata[ccksb_pkg::PixelW-1:0];

   always_comb begin
      first_pixel = (col_cnt_ff == '0) && (row_cnt_ff == '0);
      width_eff   = ccksb_pkg::clamp_side(cfg.sprite_width);
      height_eff  = ccksb_pkg::clamp_side(cfg.sprite_height);

      // Counters past a shrunk size also end the row or sprite.
      row_end = ({1'b0, col_cnt_ff} + ccksb_pkg::SideW'(1)) >= width_eff;
      last_in = row_end && (({1'b0, row_cnt_ff} + ccksb_pkg::SideW'(1)) >= height_eff);

      // Reload row and base at the first pixel of a sprite.
      scene_row_cur = first_pixel ? {cfg.sprite_y[ccksb_pkg::PosW-1], cfg.sprite_y}
                                  : scene_row_ff;
      row_base_cur  = first_pixel ? cfg.start_base : row_base_ff;

      col_pos = {cfg.sprite_x[ccksb_pkg::PosW-1], cfg.sprite_x}
              + {1'b0, {(ccksb_pkg::RowW-ccksb_pkg::CountW-1){1'b0}}, col_cnt_ff};

      // Clip both axes: negative positions carry the sign in the top bit.
      in_scene = !col_pos[ccksb_pkg::RowW-1]
              && (col_pos[ccksb_pkg::SceneW-1:0] < cfg.scene_width)
              && !scene_row_cur[ccksb_pkg::RowW-1]
              && (scene_row_cur[ccksb_pkg::SceneW-1:0] < cfg.scene_height);

      we_in = in_scene && (!cfg.key_enable || (pixel != cfg.key_color));

      offset_in = we_in
         ? row_base_cur + {{(ccksb_pkg::OffsetW-ccksb_pkg::RowW){col_pos[ccksb_pkg::RowW-1]}},
                           col_pos}
         : '0;

      // Advance the walk
      col_cnt_in   = col_cnt_ff;
      row_cnt_in   = row_cnt_ff;
      scene_row_in = scene_row_ff;
      row_base_in  = row_base_ff;
      if (req_accept) begin
         if (last_in) begin
            col_cnt_in = '0;
            row_cnt_in = '0;
         end else if (row_end) begin
            col_cnt_in   = '0;
            row_cnt_in   = row_cnt_ff + ccksb_pkg::CountW'(1);
            scene_row_in = scene_row_cur + ccksb_pkg::RowW'(1);
            row_base_in  = row_base_cur
                         + {{(ccksb_pkg::OffsetW-ccksb_pkg::SceneW){1'b0}}, cfg.scene_width};
         end else begin
            col_cnt_in   = col_cnt_ff + ccksb_pkg::CountW'(1);
            scene_row_in = scene_row_cur;
            row_base_in  = row_base_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_cnt_ff   <= '0;
         row_cnt_ff   <= '0;
         scene_row_ff <= '0;
         row_base_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_cnt_ff   <= col_cnt_in;
         row_cnt_ff   <= row_cnt_in;
         scene_row_ff <= scene_row_in;
         row_base_ff  <= row_base_in;
         if (req_accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload: load on every accepted request, hold otherwise.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_we_ff     <= we_in;
         rsp_offset_ff <= offset_in;
         rsp_pixel_ff  <= pixel;
         rsp_last_ff   <= last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_pixel_ff, rsp_offset_ff};
   assign rsp_tuser  = rsp_we_ff;
   assign rsp_tlast  = rsp_last_ff;

   `CCKSB_ASSERT_SAME(a_offset_zero_when_masked, rsp_tvalid && !rsp_tuser,
      rsp_tdata[21:0] == 22'd0, "clipped or keyed pixel carries a nonzero offset")
   `CCKSB_ASSERT_NEXT(a_last_resets_walk, req_accept && last_in,
      (col_cnt_ff == '0) && (row_cnt_ff == '0), "walk counters not cleared after last pixel")
   `CCKSB_ASSERT_NEXT(a_column_steps, req_accept && !row_end,
      col_cnt_ff == $past(col_cnt_ff) + ccksb_pkg::CountW'(1), "column counter failed to advance")
   `CCKSB_ASSERT_NEXT(a_request_yields_item, req_accept, rsp_tvalid,
      "accepted request produced no result")

endmodule

>>> tb/sv/scene_write_checker.sv
`timescale 1ns / 1ps
module scene_write_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [ccksb_pkg::CsrIdxW-1:0]    csr_index,
   input  logic [ccksb_pkg::CsrDataW-1:0]   csr_data,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [7:0]                       req_tdata,   // [7:0] pixel
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [31:0]                      rsp_tdata,   // [21:0] scene_offset, [29:22] pixel_out
   input  logic                             rsp_tuser,   // [0] write_enable
   input  logic                             rsp_tlast,   // last_pixel
   output int                               mismatches,
   output int                               writes_due
);
   import ccksb_pkg::*;

   typedef struct packed {
      logic               write_enable;
      logic [OffsetW-1:0] scene_offset;
      logic [PixelW-1:0]  pixel_out;
      logic               last_pixel;
   } scene_write_type;

   logic signed [PosW-1:0] sprite_x;
   logic signed [PosW-1:0] sprite_y;
   logic [SideW-1:0]       sprite_width;
   logic [SideW-1:0]       sprite_height;
   logic [SceneW-1:0]      scene_width;
   logic [SceneW-1:0]      scene_height;
   logic [PixelW-1:0]      key_color;
   logic                   key_enable;

   logic [CountW-1:0]      column_count;
   logic [CountW-1:0]      row_count;
   logic signed [RowW-1:0] scene_row;
   logic [OffsetW-1:0]     row_base;

   scene_write_type due_writes[$];
   scene_write_type seen;
   scene_write_type want;

   initial begin
      mismatches = 0;
      writes_due = 0;
   end

   function automatic int side_limit(input logic [SideW-1:0] v);
      if (v == '0) return 1;
      return (int'(v) > MAX_SPRITE_SIDE) ? MAX_SPRITE_SIDE : int'(v);
   endfunction

   // Work out the scene write for one sprite pixel and advance the raster walk.
   function automatic scene_write_type blit_pixel(input logic [PixelW-1:0] px);
      int              w;
      int              h;
      int              col;
      logic            in_scene;
      logic            row_end;
      scene_write_type r;
      w = side_limit(sprite_width);
      h = side_limit(sprite_height);
      if (column_count == '0 && row_count == '0) begin
         scene_row = sprite_y;
         row_base  = OffsetW'(int'(sprite_y) * int'(scene_width));
      end
      col = int'(sprite_x) + int'(column_count);
      in_scene = col >= 0 && col < int'(scene_width) &&
                 scene_row >= 0 && int'(scene_row) < int'(scene_height);
      r.write_enable = in_scene && (!key_enable || px != key_color);
      r.scene_offset = r.write_enable ? row_base + OffsetW'(col) : '0;
      r.pixel_out    = px;
      row_end        = int'(column_count) + 1 >= w;
      r.last_pixel   = row_end && int'(row_count) + 1 >= h;
      if (r.last_pixel) begin
         column_count = '0;
         row_count    = '0;
      end else if (row_end) begin
         column_count = '0;
         row_count++;
         scene_row++;
         row_base += scene_width;
      end else begin
         column_count++;
      end
      return r;
   endfunction

   task automatic compare_field(input string name, input int want_v, input int got_v);
      if (want_v != got_v) begin
         $display("%0t: %s expected %0h got %0h", $time, name, want_v, got_v);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         sprite_x      = '0;
         sprite_y      = '0;
         sprite_width  = SideW'(1);
         sprite_height = SideW'(1);
         scene_width   = SceneW'(640);
         scene_height  = SceneW'(480);
         key_color     = '0;
         key_enable    = 1'b1;
         column_count  = '0;
         row_count     = '0;
         scene_row     = '0;
         row_base      = '0;
         due_writes.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_SPRITE_X:      sprite_x      = csr_data[PosW-1:0];
               CSR_SPRITE_Y:      sprite_y      = csr_data[PosW-1:0];
               CSR_SPRITE_WIDTH:  sprite_width  = csr_data[SideW-1:0];
               CSR_SPRITE_HEIGHT: sprite_height = csr_data[SideW-1:0];
               CSR_SCENE_WIDTH:   scene_width   = csr_data[SceneW-1:0];
               CSR_SCENE_HEIGHT:  scene_height  = csr_data[SceneW-1:0];
               CSR_KEY_COLOR:     key_color     = csr_data[PixelW-1:0];
               CSR_KEY_ENABLE:    key_enable    = csr_data[0];
               default: ;
            endcase
         end
         // Match results before queueing this edge's request, since each result is registered.
         if (rsp_tvalid && rsp_tready) begin
            seen.write_enable = rsp_tuser;
            seen.scene_offset = rsp_tdata[OffsetW-1:0];
            seen.pixel_out    = rsp_tdata[OffsetW+PixelW-1:OffsetW];
            seen.last_pixel   = rsp_tlast;
            if (due_writes.size() == 0) begin
               $display("%0t: unexpected scene write, expected none got %h", $time, seen);
               mismatches++;
            end else begin
               want = due_writes.pop_front();
               compare_field("write_enable", want.write_enable, seen.write_enable);
               compare_field("scene_offset", want.scene_offset, seen.scene_offset);
               compare_field("pixel_out", want.pixel_out, seen.pixel_out);
               compare_field("last_pixel", want.last_pixel, seen.last_pixel);
            end
         end
         if (req_tvalid && req_tready) begin
            due_writes.push_back(blit_pixel(req_tdata));
         end
      end
      writes_due = due_writes.size();
   end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
   import ccksb_pkg::*;

   // Random part stops once this many pixels have gone in; the tail runs without idling.
   localparam int PIXEL_BUDGET = 1800;
   localparam int QUIET_TAIL   = 150;
   localparam int HOLD_AFTER   = 600;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                csr_valid  = 1'b0;
   logic                csr_ready;
   logic [CsrIdxW-1:0]  csr_index  = '0;
   logic [CsrDataW-1:0] csr_data   = '0;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [7:0]          req_tdata  = '0;   // [7:0] pixel
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [31:0]         rsp_tdata;         // [21:0] scene_offset, [29:22] pixel_out
   logic                rsp_tuser;         // [0] write_enable
   logic                rsp_tlast;         // last_pixel

   int                  mismatches;
   int                  writes_due;
   int                  pixels_sent     = 0;
   bit                  gaps_on         = 1'b0;
   bit                  quiet           = 1'b0;
   bit                  long_hold_armed = 1'b0;
   logic [PixelW-1:0]   key_shadow      = '0;

   clipped_color_key_sprite_blit DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   scene_write_checker write_check (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .mismatches (mismatches),
      .writes_due (writes_due)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin
      #10_000_000;
      $display("clipped_color_key_sprite_blit test failed");
      $finish;
   end

   // Hold valid on the channel until the block takes the write; leave csr_valid
   // high so back-to-back writes need no drop in between.
   task automatic write_reg(input csr_index_type idx, input logic [CsrDataW-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      if (idx == CSR_KEY_COLOR) key_shadow = value[PixelW-1:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // Offer one pixel request, optionally after a random idle burst, and wait for it
   // to be taken. Valid stays high afterwards so the next request follows without a gap.
   task automatic push_pixel(input logic [PixelW-1:0] px);
      if (gaps_on && !quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pixels_sent++;
   endtask

   // Drop valid and pause until every scene write owed has come back.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (writes_due != 0);
      @(posedge clock);
   endtask

   // Register values: mostly small sprites near the scene edges so that clipping and
   // row ends happen often, with the extremes and full random words mixed in.
   function automatic logic [CsrDataW-1:0] pick_value(input csr_index_type idx);
      int roll;
      roll = $urandom_range(0, 15);
      case (idx)
         CSR_SPRITE_X, CSR_SPRITE_Y: begin
            if (roll == 0) return 12'h800;
            if (roll == 1) return 12'h7FF;
            if (roll < 5) return CsrDataW'($urandom);
            return CsrDataW'($urandom_range(0, 40) - 12);
         end
         CSR_SPRITE_WIDTH, CSR_SPRITE_HEIGHT: begin
            if (roll == 0) return '0;
            if (roll == 1) return 12'd256;
            if (roll == 2) return CsrDataW'($urandom);
            return CsrDataW'($urandom_range(1, 6));
         end
         CSR_SCENE_WIDTH, CSR_SCENE_HEIGHT: begin
            if (roll == 0) return '0;
            if (roll == 1) return '1;
            if (roll < 4) return CsrDataW'($urandom);
            return CsrDataW'($urandom_range(1, 20));
         end
         default: return CsrDataW'($urandom);
      endcase
   endfunction

   // Result side: random stall bursts and ready stretches, one long hold-off part way
   // through so the output backs up and the request side stalls, none in the tail.
   initial begin
      int stretch;
      bit held;
      stretch = 0;
      held    = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_armed && !held) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
         end else if (quiet) begin
            rsp_tready <= 1'b1;
         end else if (stretch > 0) begin
            stretch--;
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            stretch = $urandom_range(1, 10) - 1;
         end else begin
            rsp_tready <= 1'b1;
            stretch = $urandom_range(0, 40);
         end
      end
   end

   initial begin
      int count;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: single-pixel sprites, keyed on colour zero, so the first
      // pixel is dropped with a zero offset and the others land at offset zero.
      push_pixel(8'h00);
      push_pixel(8'hFF);
      push_pixel(8'h5A);
      wait_idle();

      // 3x2 sprite at (-1,-1) on a 2x1 scene, opaque: the top row and the left
      // column are clipped, and the key colour is still written.
      write_reg(CSR_SPRITE_X, 12'hFFF);
      write_reg(CSR_SPRITE_Y, 12'hFFF);
      write_reg(CSR_SPRITE_WIDTH, 12'd3);
      write_reg(CSR_SPRITE_HEIGHT, 12'd2);
      write_reg(CSR_SCENE_WIDTH, 12'd2);
      write_reg(CSR_SCENE_HEIGHT, 12'd1);
      write_reg(CSR_KEY_COLOR, 12'h0FF);
      write_reg(CSR_KEY_ENABLE, 12'h000);
      csr_valid <= 1'b0;
      push_pixel(8'hFF);
      push_pixel(8'h01);
      push_pixel(8'h80);
      push_pixel(8'hFF);
      push_pixel(8'h7F);
      push_pixel(8'hFE);
      wait_idle();

      // Zero sprite sides act as one; an empty scene clips everything.
      write_reg(CSR_SPRITE_X, 12'h000);
      write_reg(CSR_SPRITE_Y, 12'h000);
      write_reg(CSR_SPRITE_WIDTH, 12'h000);
      write_reg(CSR_SPRITE_HEIGHT, 12'h000);
      write_reg(CSR_SCENE_WIDTH, 12'h000);
      write_reg(CSR_SCENE_HEIGHT, 12'h000);
      write_reg(CSR_KEY_COLOR, 12'h03C);
      write_reg(CSR_KEY_ENABLE, 12'hFFF);
      csr_valid <= 1'b0;
      push_pixel(8'h3C);
      push_pixel(8'hC3);
      wait_idle();

      // Far corner of the largest scene with an oversized width: the offset wraps,
      // and the key colour is skipped again.
      write_reg(CSR_SPRITE_X, 12'h7FF);
      write_reg(CSR_SPRITE_Y, 12'h7FF);
      write_reg(CSR_SPRITE_WIDTH, 12'hFFF);
      write_reg(CSR_SPRITE_HEIGHT, 12'h001);
      write_reg(CSR_SCENE_WIDTH, 12'hFFF);
      write_reg(CSR_SCENE_HEIGHT, 12'hFFF);
      csr_valid <= 1'b0;
      push_pixel(8'h00);
      push_pixel(8'h3C);
      push_pixel(8'hFF);
      wait_idle();

      // Shrink the width mid-row: the column is already past the new end, so the
      // sprite ends on the next pixel; the next one starts at the far left.
      write_reg(CSR_SPRITE_WIDTH, 12'd2);
      write_reg(CSR_SPRITE_X, 12'h800);
      csr_valid <= 1'b0;
      push_pixel(8'h11);
      push_pixel(8'h22);
      push_pixel(8'h33);

      // Random phases: reprogram while idle (often mid-sprite), then stream pixels,
      // a third of them in the key colour.
      while (pixels_sent < PIXEL_BUDGET) begin
         wait_idle();
         for (int i = 0; i < 8; i++) begin
            if ($urandom_range(0, 2) == 0) write_reg(csr_index_type'(i),
                                                     pick_value(csr_index_type'(i)));
         end
         csr_valid <= 1'b0;
         if (!long_hold_armed && pixels_sent >= HOLD_AFTER) begin
            long_hold_armed = 1'b1;
            gaps_on = 1'b0;
            count = 40;
         end else begin
            gaps_on = $urandom_range(0, 2) != 0;
            count = $urandom_range(1, 48);
         end
         repeat (count) begin
            push_pixel(($urandom_range(0, 2) == 0) ? key_shadow : PixelW'($urandom));
         end
         quiet = pixels_sent >= PIXEL_BUDGET - QUIET_TAIL;
      end

      wait_idle();
      repeat (4) @(posedge clock);
      if (mismatches == 0) begin
         $display("clipped_color_key_sprite_blit test passed");
      end else begin
         $display("clipped_color_key_sprite_blit test failed");
      end
      $finish;
   end

endmodule

>>> clipped_color_key_sprite_blit.f
+incdir+hw/rtl
hw/rtl/ccksb_pkg.sv
hw/rtl/ccksb_cfg.sv
hw/rtl/clipped_color_key_sprite_blit.sv
tb/sv/scene_write_checker.sv
tb/sv/tb.sv
